@@ hdl/cbfm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbfm_pkg
// Shared types and constants of the clock buffer frame manager: table sizes,
// request and status codes, the per-frame metadata word and the result layout.
// ----------------------------------------------------------------------------
package cbfm_pkg;

  // table geometry
  localparam int NUM_FRAMES = 64;
  localparam int PIN_BITS   = 8;
  localparam int TAG_BITS   = 32;

  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int CNT_W    = $clog2(NUM_FRAMES + 1);
  localparam int CFG_W    = 7;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam int ACTIVE_RST = 64;
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  // stream payload widths
  localparam int IN_W       = FRAME_W + TAG_BITS + 1;
  localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int RES_W      = FRAME_W + STATUS_W + 2 + TAG_BITS;
  localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

  // bit positions of the result fields in the output tdata
  localparam int OUT_STATUS_LSB = FRAME_W;
  localparam int OUT_EV_BIT     = FRAME_W + STATUS_W;
  localparam int OUT_ED_BIT     = FRAME_W + STATUS_W + 1;
  localparam int OUT_TAG_LSB    = FRAME_W + STATUS_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_PIN     = 2'd1,
    MODE_UNPIN   = 2'd2,
    MODE_DISPOSE = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ALL_PINNED = 2'd1,
    ST_NOT_PINNED = 2'd2,
    ST_PIN_OVF    = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_OP    = 5'b00010,
    S_SWEEP = 5'b00100,
    S_FB    = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  // per-frame metadata word held in the frame ram
  typedef struct packed {
    logic [PIN_BITS-1:0] pin_cnt;
    logic                ref_bit;
    logic                dirty_bit;
    logic                valid_bit;
    logic [TAG_BITS-1:0] tag;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // result item, frame index in the lowest bits
  typedef struct packed {
    logic [TAG_BITS-1:0] evict_tag;
    logic                evict_dirty;
    logic                evict_valid;
    status_e             status;
    logic [FRAME_W-1:0]  frame_out;
  } result_t;

  // register value mapped into the usable frame count
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] a);
    logic [CNT_W-1:0] n;
    if (a == '0) begin
      n = CNT_W'(1);
    end else if (CNT_W'(a) > CNT_W'(NUM_FRAMES)) begin
      n = CNT_W'(NUM_FRAMES);
    end else begin
      n = CNT_W'(a);
    end
    return n;
  endfunction

endpackage

@@ hdl/cbfm_ram.sv @@
// ----------------------------------------------------------------------------
// cbfm_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module cbfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/clock_buffer_frame_manager.sv @@
// ----------------------------------------------------------------------------
// clock_buffer_frame_manager
// Buffer frame table with pin counts and clock (second chance) replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser carries the mode (allocate,
// pin, unpin, dispose), tdata the frame index, page tag and dirty flag. Each
// request gives exactly one result on the m_axis channel, carrying the frame,
// a status code and, for an allocation, the evicted page's tag, valid and
// dirty marks so the caller can drop it from its lookup and write it back.
// The frame count register is written over cfg_we_i/cfg_wdata_i; the user
// must do so only while idle, the block does not enforce it. A write also
// parks the clock hand on the last active frame. Frame metadata lives in
// one ram with a registered read port; a row of written flags makes
// never-written or disposed frames read as empty. Pin, unpin and dispose
// read the frame on transfer and update it in the op state; a frame outside
// the active range goes straight to the holding state. An allocation reads
// one frame per cycle in the sweep state until it finds a victim; a full
// pass of the active frames takes the fallback frame or reports all pinned.
// The block takes a new request only when its sequencer is idle; a finished
// result waits in the output register while the receiver stalls, and the
// next request may be taken meanwhile. Its result then waits in the holding
// state until the output register frees up.
// Reset empties the table at once (written flags cleared), sets the frame
// count to its full value and the hand to the last frame.
// ----------------------------------------------------------------------------
module clock_buffer_frame_manager (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write
  input  logic                             cfg_we_i,
  input  logic [cbfm_pkg::CFG_W-1:0]       cfg_wdata_i,
  // request stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: frame_index, page_tag, dirty_flag, zero fill
  input  logic [cbfm_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: mode
  input  logic [cbfm_pkg::MODE_W-1:0]      s_axis_tuser_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: frame_out, status, evict_valid, evict_dirty, evict_tag, zero fill
  output logic [cbfm_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  import cbfm_pkg::*;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     active_q, active_d;
  logic [CNT_W-1:0]     n_act;
  logic [FRAME_W-1:0]   hand_q, hand_d, hand_next;
  logic [CNT_W-1:0]     cnt_q, cnt_d, cnt_inc;

  mode_e                req_mode_q, req_mode_d;
  logic [FRAME_W-1:0]   req_idx_q, req_idx_d;
  logic [TAG_BITS-1:0]  req_tag_q, req_tag_d;
  logic                 req_dirty_q, req_dirty_d;

  logic                 have_fb_q, have_fb_d;
  logic [FRAME_W-1:0]   fb_idx_q, fb_idx_d;
  logic                 fb_valid_q, fb_valid_d;
  logic                 fb_dirty_q, fb_dirty_d;
  logic [TAG_BITS-1:0]  fb_tag_q, fb_tag_d;

  result_t              res_q, res_d;
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [NUM_FRAMES-1:0] wr_q, wr_d;
  logic                  rd_wr_q;

  logic                 ram_we, ram_re;
  logic [FRAME_W-1:0]   ram_waddr, ram_raddr;
  meta_t                ram_wdata, ram_rdata, cur, fresh, upd;

  logic                 accept, step;
  mode_e                in_mode;
  logic [FRAME_W-1:0]   in_idx;
  logic [TAG_BITS-1:0]  in_tag;
  logic                 in_dirty;

  // request fields
  assign in_mode  = mode_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[FRAME_W-1:0];
  assign in_tag   = s_axis_tdata_i[FRAME_W +: TAG_BITS];
  assign in_dirty = s_axis_tdata_i[FRAME_W + TAG_BITS];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign n_act     = active_count(active_q);
  assign hand_next = ((CNT_W'(hand_q) + CNT_W'(1)) == n_act) ? '0 : hand_q + FRAME_W'(1);
  assign cnt_inc   = cnt_q + CNT_W'(1);

  // frame metadata, empty unless the entry was written
  assign cur = rd_wr_q ? ram_rdata : '0;

  // word installed on a taken victim
  always_comb begin
    fresh           = '0;
    fresh.pin_cnt   = PIN_BITS'(1);
    fresh.ref_bit   = 1'b1;
    fresh.valid_bit = 1'b1;
    fresh.tag       = req_tag_q;
  end

  cbfm_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_FRAMES)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    hand_d      = hand_q;
    cnt_d       = cnt_q;
    req_mode_d  = req_mode_q;
    req_idx_d   = req_idx_q;
    req_tag_d   = req_tag_q;
    req_dirty_d = req_dirty_q;
    have_fb_d   = have_fb_q;
    fb_idx_d    = fb_idx_q;
    fb_valid_d  = fb_valid_q;
    fb_dirty_d  = fb_dirty_q;
    fb_tag_d    = fb_tag_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_d        = wr_q;
    ram_we      = 1'b0;
    ram_waddr   = hand_q;
    ram_wdata   = cur;
    ram_re      = 1'b0;
    ram_raddr   = hand_q;
    upd         = cur;
    step        = 1'b0;

    // output register drains on a transfer
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    // frame count write parks the hand on the last active frame
    if (cfg_we_i) begin
      active_d = cfg_wdata_i;
      hand_d   = FRAME_W'(active_count(cfg_wdata_i) - CNT_W'(1));
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_mode_d  = in_mode;
          req_idx_d   = in_idx;
          req_tag_d   = in_tag;
          req_dirty_d = in_dirty;
          if (in_mode == MODE_ALLOC) begin
            ram_re    = 1'b1;
            ram_raddr = hand_q;
            cnt_d     = '0;
            have_fb_d = 1'b0;
            state_d   = S_SWEEP;
          end else if (CNT_W'(in_idx) < n_act) begin
            ram_re    = 1'b1;
            ram_raddr = in_idx;
            state_d   = S_OP;
          end else begin
            // frame outside the active range is ignored
            res_d           = '0;
            res_d.frame_out = in_idx;
            res_d.status    = ST_OK;
            state_d         = S_HOLD;
          end
        end
      end

      // pin, unpin or dispose on the frame just read
      S_OP: begin
        res_d           = '0;
        res_d.frame_out = req_idx_q;
        res_d.status    = ST_OK;
        ram_waddr       = req_idx_q;
        unique case (req_mode_q)
          MODE_PIN: begin
            upd.ref_bit = 1'b1;
            if (cur.pin_cnt == PIN_MAX) begin
              res_d.status = ST_PIN_OVF;
            end else begin
              upd.pin_cnt = cur.pin_cnt + PIN_BITS'(1);
            end
            ram_we          = 1'b1;
            ram_wdata       = upd;
            wr_d[req_idx_q] = 1'b1;
          end
          MODE_UNPIN: begin
            if (cur.pin_cnt == '0) begin
              res_d.status = ST_NOT_PINNED;
            end else begin
              upd.pin_cnt     = cur.pin_cnt - PIN_BITS'(1);
              upd.dirty_bit   = cur.dirty_bit | req_dirty_q;
              ram_we          = 1'b1;
              ram_wdata       = upd;
              wr_d[req_idx_q] = 1'b1;
            end
          end
          MODE_DISPOSE: begin
            wr_d[req_idx_q] = 1'b0;
          end
          default: begin
          end
        endcase
        state_d = S_HOLD;
      end

      // clock sweep, one frame per cycle, next read issued alongside
      S_SWEEP: begin
        if (cur.pin_cnt != '0) begin
          hand_d = hand_next;
          step   = 1'b1;
        end else if (cur.ref_bit) begin
          upd.ref_bit  = 1'b0;
          ram_we       = 1'b1;
          ram_waddr    = hand_q;
          ram_wdata    = upd;
          wr_d[hand_q] = 1'b1;
          if (!have_fb_q) begin
            have_fb_d  = 1'b1;
            fb_idx_d   = hand_q;
            fb_valid_d = cur.valid_bit;
            fb_dirty_d = cur.dirty_bit;
            fb_tag_d   = cur.tag;
          end
          hand_d = hand_next;
          step   = 1'b1;
        end else begin
          // unpinned and unreferenced: victim, hand stays here
          ram_we            = 1'b1;
          ram_waddr         = hand_q;
          ram_wdata         = fresh;
          wr_d[hand_q]      = 1'b1;
          res_d.frame_out   = hand_q;
          res_d.status      = ST_OK;
          res_d.evict_valid = cur.valid_bit;
          res_d.evict_dirty = cur.dirty_bit;
          res_d.evict_tag   = cur.valid_bit ? cur.tag : '0;
          state_d           = S_HOLD;
        end
        if (step) begin
          cnt_d = cnt_inc;
          if (cnt_inc == n_act) begin
            if (have_fb_d) begin
              state_d = S_FB;
            end else begin
              res_d        = '0;
              res_d.status = ST_ALL_PINNED;
              state_d      = S_HOLD;
            end
          end else begin
            ram_re    = 1'b1;
            ram_raddr = hand_next;
          end
        end
      end

      // full pass without a clean frame: take the first referenced one
      S_FB: begin
        ram_we            = 1'b1;
        ram_waddr         = fb_idx_q;
        ram_wdata         = fresh;
        wr_d[fb_idx_q]    = 1'b1;
        hand_d            = fb_idx_q;
        res_d.frame_out   = fb_idx_q;
        res_d.status      = ST_OK;
        res_d.evict_valid = fb_valid_q;
        res_d.evict_dirty = fb_dirty_q;
        res_d.evict_tag   = fb_valid_q ? fb_tag_q : '0;
        state_d           = S_HOLD;
      end

      // hand the result to the output register once it is free
      S_HOLD: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= CFG_W'(ACTIVE_RST);
      hand_q      <= FRAME_W'(active_count(CFG_W'(ACTIVE_RST)) - CNT_W'(1));
      cnt_q       <= '0;
      have_fb_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      hand_q      <= hand_d;
      cnt_q       <= cnt_d;
      have_fb_q   <= have_fb_d;
      out_valid_q <= out_valid_d;
      wr_q        <= wr_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_mode_q  <= req_mode_d;
    req_idx_q   <= req_idx_d;
    req_tag_q   <= req_tag_d;
    req_dirty_q <= req_dirty_d;
    fb_idx_q    <= fb_idx_d;
    fb_valid_q  <= fb_valid_d;
    fb_dirty_q  <= fb_dirty_d;
    fb_tag_q    <= fb_tag_d;
    res_q       <= res_d;
    out_q       <= out_d;
    if (ram_re) begin
      rd_wr_q <= wr_q[ram_raddr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - RES_W){1'b0}}, out_q};

endmodule

@@ hdl/cbfm_checker.sv @@
// ----------------------------------------------------------------------------
// cbfm_checker
// Port-level checks of the frame manager, bound to the top level.
// ----------------------------------------------------------------------------
module cbfm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [cbfm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  import cbfm_pkg::*;

  logic                s_xfer;
  logic [STATUS_W-1:0] r_status;
  logic                r_ev;
  logic                r_ed;
  logic [TAG_BITS-1:0] r_tag;
  logic [FRAME_W-1:0]  r_frame;

  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign r_frame  = m_axis_tdata_o[FRAME_W-1:0];
  assign r_status = m_axis_tdata_o[OUT_STATUS_LSB +: STATUS_W];
  assign r_ev     = m_axis_tdata_o[OUT_EV_BIT];
  assign r_ed     = m_axis_tdata_o[OUT_ED_BIT];
  assign r_tag    = m_axis_tdata_o[OUT_TAG_LSB +: TAG_BITS];

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // the sequencer is busy right after a request transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // failed allocation reports frame zero and no eviction
  a_all_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (r_status == ST_ALL_PINNED) |->
      (r_frame == '0) && !r_ev && !r_ed && (r_tag == '0))
    else $error("all-pinned result carries eviction data");

  // no evicted tag without a valid victim
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !r_ev |-> (r_tag == '0))
    else $error("evicted tag without valid victim");

endmodule

bind clock_buffer_frame_manager cbfm_checker u_cbfm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
